// ===== sv/decimal_id_to_hex_frame_encoder_macros.svh =====
// Assertion macros for the decimal id to hex frame encoder.
// Each check is sampled on the rising clock edge and held off during reset.
`ifndef DECIMAL_ID_TO_HEX_FRAME_ENCODER_MACROS_SVH
`define DECIMAL_ID_TO_HEX_FRAME_ENCODER_MACROS_SVH

`ifndef SYNTH

// Property that holds in the same cycle
`define DHFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent now, consequent in the next cycle
`define DHFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DHFE_ASSERT(label, prop, msg)
`define DHFE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== sv/dhfe_pkg.sv =====
`default_nettype none

package dhfe_pkg;

    // Most digits held in one number
    localparam logic [3:0] MAX_DIGITS = 4'd15;

    // Parser phases
    localparam logic [1:0] PH_LEAD   = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_IGNORE = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_NONDIGIT = 3'd2;
    localparam logic [2:0] ST_TOOLONG  = 3'd3;
    localparam logic [2:0] ST_TOOBIG   = 3'd4;

    // Frame control bytes
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    // Positions within the 12-byte frame
    localparam logic [3:0] IDX_STX = 4'd0;
    localparam logic [3:0] IDX_CR  = 4'd9;
    localparam logic [3:0] IDX_LF  = 4'd10;
    localparam logic [3:0] IDX_ETX = 4'd11;

    // Upper-case ASCII for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
            ch = 8'h30 + {4'h0, nib};
        else
            ch = 8'h37 + {4'h0, nib};
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== sv/decimal_id_to_hex_frame_encoder.sv =====
// The first result of a character is registered and shows in the cycle after its request
// is taken. Throughput: one character per cycle while no result is pending; a character
// that ends a number or raises an error holds the input until its report (1 item) or
// frame (12 items, one per cycle while m_tready is high) has drained, limited by the
// single result register. Reset (rst_n, asynchronous, active low) clears the parser to
// the leading whitespace phase and empties the result register.
`default_nettype none

`include "decimal_id_to_hex_frame_encoder_macros.svh"

module decimal_id_to_hex_frame_encoder
    import dhfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] frame_byte, [10:8] status, rest zero
    output logic             m_tlast    // last
);

    // Parser state
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  count_reg, count_next;
    logic [31:0] acc_reg, acc_next;
    logic        big_reg, big_next;

    // Result register
    logic        job_valid_reg;
    logic        job_err_reg;
    logic [2:0]  job_status_reg;
    logic [31:0] job_value_reg;
    logic [3:0]  job_idx_reg;

    // New job from this character
    logic        emit;
    logic        emit_err;
    logic [2:0]  emit_status;

    logic        s_fire, m_fire, job_last, job_done;
    logic        is_space, is_digit, is_nul, in_digits;
    logic [3:0]  eff_count;
    logic [31:0] eff_acc;
    logic        eff_big;
    logic [35:0] acc_x10;
    logic [35:0] acc_sum;
    logic [7:0]  frame_byte;

    // Handshake
    assign job_last = job_err_reg || (job_idx_reg == IDX_ETX);
    assign m_fire   = job_valid_reg && m_tready;
    assign job_done = m_fire && job_last;
    assign s_tready = !job_valid_reg || job_done;
    assign s_fire   = s_tvalid && s_tready;

    // Character classes
    assign is_nul   = (s_tdata == CH_NUL);
    assign is_space = (s_tdata == CH_SP) || (s_tdata == CH_TAB) ||
                      (s_tdata == CH_CR) || (s_tdata == CH_LF);
    assign is_digit = (s_tdata >= 8'h30) && (s_tdata <= 8'h39);

    // A non-blank in the lead phase starts a fresh number
    assign in_digits = (phase_reg == PH_DIGITS) ||
                       ((phase_reg == PH_LEAD) && !is_nul && !is_space);
    assign eff_acc   = (phase_reg == PH_DIGITS) ? acc_reg   : 32'd0;
    assign eff_count = (phase_reg == PH_DIGITS) ? count_reg : 4'd0;
    assign eff_big   = (phase_reg == PH_DIGITS) ? big_reg   : 1'b0;

    // value * 10 + digit, kept wide to catch overflow
    assign acc_x10 = ({4'b0000, eff_acc} << 3) + ({4'b0000, eff_acc} << 1);
    assign acc_sum = acc_x10 + {32'd0, s_tdata[3:0]};

    // Parser next state
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        big_next    = big_reg;
        emit        = 1'b0;
        emit_err    = 1'b0;
        emit_status = ST_OK;
        if (s_fire)
        begin
            if (in_digits)
            begin
                if (is_nul || is_space)
                begin
                    emit        = 1'b1;
                    emit_err    = eff_big;
                    emit_status = eff_big ? ST_TOOBIG : ST_OK;
                    phase_next  = is_nul ? PH_LEAD : PH_IGNORE;
                    count_next  = 4'd0;
                    acc_next    = 32'd0;
                    big_next    = 1'b0;
                end
                else if (!is_digit)
                begin
                    emit        = 1'b1;
                    emit_err    = 1'b1;
                    emit_status = ST_NONDIGIT;
                    phase_next  = PH_IGNORE;
                    count_next  = 4'd0;
                    acc_next    = 32'd0;
                    big_next    = 1'b0;
                end
                else if (eff_count >= MAX_DIGITS)
                begin
                    emit        = 1'b1;
                    emit_err    = 1'b1;
                    emit_status = ST_TOOLONG;
                    phase_next  = PH_IGNORE;
                    count_next  = 4'd0;
                    acc_next    = 32'd0;
                    big_next    = 1'b0;
                end
                else
                begin
                    phase_next = PH_DIGITS;
                    count_next = eff_count + 4'd1;
                    acc_next   = acc_sum[31:0];
                    big_next   = eff_big || (acc_sum[35:32] != 4'd0);
                end
            end
            else
            begin
                case (phase_reg)
                    PH_LEAD:
                    begin
                        // blanks are skipped; a zero byte means an empty message
                        if (is_nul)
                        begin
                            emit        = 1'b1;
                            emit_err    = 1'b1;
                            emit_status = ST_EMPTY;
                            count_next  = 4'd0;
                            acc_next    = 32'd0;
                            big_next    = 1'b0;
                        end
                    end
                    default:
                    begin
                        // ignore phase, also the unused code
                        if (is_nul)
                        begin
                            phase_next = PH_LEAD;
                            count_next = 4'd0;
                            acc_next   = 32'd0;
                            big_next   = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            count_reg <= 4'd0;
            acc_reg   <= 32'd0;
            big_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            acc_reg   <= acc_next;
            big_reg   <= big_next;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            job_idx_reg   <= IDX_STX;
        end
        else if (emit)
        begin
            job_valid_reg <= 1'b1;
            job_idx_reg   <= IDX_STX;
        end
        else if (job_done)
        begin
            job_valid_reg <= 1'b0;
        end
        else if (m_fire)
        begin
            job_idx_reg <= job_idx_reg + 4'd1;
        end
    end

    // Result payload; hex digits leave from the top nibble
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            job_err_reg    <= emit_err;
            job_status_reg <= emit_status;
            job_value_reg  <= eff_acc;
        end
        else if (m_fire && (job_idx_reg != IDX_STX))
        begin
            job_value_reg <= {job_value_reg[27:0], 4'h0};
        end
    end

    // Output byte
    always_comb
    begin
        if (job_err_reg)
            frame_byte = CH_NUL;
        else
        begin
            case (job_idx_reg)
                IDX_STX: frame_byte = CH_STX;
                IDX_CR:  frame_byte = CH_CR;
                IDX_LF:  frame_byte = CH_LF;
                IDX_ETX: frame_byte = CH_ETX;
                default: frame_byte = hex_char(job_value_reg[31:28]);
            endcase
        end
    end

    assign m_tvalid = job_valid_reg;
    assign m_tdata  = {5'b00000, job_status_reg, frame_byte};
    assign m_tlast  = job_last;

    // Checks
    `DHFE_ASSERT(a_err_item, (m_tvalid && (m_tdata[10:8] != ST_OK)) |->
        ((m_tdata[7:0] == CH_NUL) && m_tlast), "error item must be a zero byte with last")
    `DHFE_ASSERT(a_idx_range, job_valid_reg |-> (job_idx_reg <= IDX_ETX),
        "frame index beyond last byte")
    `DHFE_ASSERT(a_count_range, count_reg <= MAX_DIGITS, "digit count beyond limit")
    `DHFE_ASSERT_NEXT(a_drain, (m_tvalid && m_tready && m_tlast && !emit), !m_tvalid,
        "result still shown after its last item was taken")

endmodule

`default_nettype wire

// ===== tb/sv/dhfe_frame_check.sv =====
`timescale 1ns / 100ps

// Watches both streams of the encoder, predicts the results of every character
// request taken and compares each result request with the oldest prediction.
module dhfe_frame_check
    import dhfe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [7:0] frame_byte, [10:8] status, rest zero
    input  wire logic        m_tlast,   // last
    output int               mismatches,
    output int               pending_results
);

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] ASCII_A    = 8'h41;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [2:0] status;
        logic       last;
    } frame_item_t;

    frame_item_t frame_items_due [$];

    // Parser copy
    logic [1:0]  parse_phase;
    logic [3:0]  held_digits;
    logic [31:0] number_value;
    logic        number_overflow;

    task automatic clear_number();
        held_digits     = '0;
        number_value    = '0;
        number_overflow = 1'b0;
    endtask

    task automatic queue_status(input logic [2:0] st);
        frame_item_t item;
        item.frame_byte = CH_NUL;
        item.status     = st;
        item.last       = 1'b1;
        frame_items_due.push_back(item);
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic is_last);
        frame_item_t item;
        item.frame_byte = b;
        item.status     = ST_OK;
        item.last       = is_last;
        frame_items_due.push_back(item);
    endtask

    task automatic note_fault(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, what);
    endtask

    // One character through the parser; pushes the results it causes
    task automatic parse_char(input logic [7:0] c);
        logic        is_ws;
        logic        is_digit;
        logic [35:0] wide;
        logic [3:0]  nib;
        is_ws    = (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
        is_digit = (c >= ASCII_ZERO) && (c <= ASCII_NINE);

        if (parse_phase == PH_LEAD)
        begin
            if (c == CH_NUL)
            begin
                queue_status(ST_EMPTY);
                clear_number();
                return;
            end
            if (is_ws)
                return;
            clear_number();
            parse_phase = PH_DIGITS;
        end

        if (parse_phase == PH_DIGITS)
        begin
            if (c == CH_NUL || is_ws)
            begin
                // number closed: frame, or overflow report
                if (number_overflow)
                    queue_status(ST_TOOBIG);
                else
                begin
                    queue_byte(CH_STX, 1'b0);
                    for (int i = 7; i >= 0; i--)
                    begin
                        nib = number_value[i*4 +: 4];
                        if (nib < 4'd10)
                            queue_byte(ASCII_ZERO + {4'h0, nib}, 1'b0);
                        else
                            queue_byte(ASCII_A + {4'h0, nib} - 8'd10, 1'b0);
                    end
                    queue_byte(CH_CR, 1'b0);
                    queue_byte(CH_LF, 1'b0);
                    queue_byte(CH_ETX, 1'b1);
                end
                clear_number();
                parse_phase = is_ws ? PH_IGNORE : PH_LEAD;
            end
            else if (!is_digit)
            begin
                queue_status(ST_NONDIGIT);
                clear_number();
                parse_phase = PH_IGNORE;
            end
            else if (held_digits >= MAX_DIGITS)
            begin
                queue_status(ST_TOOLONG);
                clear_number();
                parse_phase = PH_IGNORE;
            end
            else
            begin
                wide = {4'h0, number_value} * 36'd10 + {32'h0, c[3:0]};
                if (wide[35:32] != 4'h0)
                    number_overflow = 1'b1;
                number_value = wide[31:0];
                held_digits  = held_digits + 4'd1;
            end
        end
        else if (c == CH_NUL)
        begin
            // ignore phase ends at the zero byte
            clear_number();
            parse_phase = PH_LEAD;
        end
    endtask

    // Result check first, then prediction for the request taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        frame_item_t due;
        if (!rst_n)
        begin
            parse_phase = PH_LEAD;
            clear_number();
            frame_items_due.delete();
            mismatches      = 0;
            pending_results = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (frame_items_due.size() == 0)
                    note_fault($sformatf("unexpected result: byte %h status %0d last %b",
                                         m_tdata[7:0], m_tdata[10:8], m_tlast));
                else
                begin
                    due = frame_items_due.pop_front();
                    if (m_tdata[7:0] !== due.frame_byte || m_tdata[10:8] !== due.status ||
                        m_tlast !== due.last || m_tdata[15:11] !== 5'h00)
                        note_fault($sformatf({"result mismatch: expected byte %h status %0d ",
                                              "last %b, got byte %h status %0d last %b pad %h"},
                                             due.frame_byte, due.status, due.last,
                                             m_tdata[7:0], m_tdata[10:8], m_tlast,
                                             m_tdata[15:11]));
                end
            end
            if (s_tvalid && s_tready)
                parse_char(s_tdata);
            pending_results = frame_items_due.size();
        end
    end

endmodule

// ===== tb/sv/decimal_id_to_hex_frame_encoder_tb.sv =====
`timescale 1ns / 100ps

module decimal_id_to_hex_frame_encoder_tb;
    import dhfe_pkg::*;

    localparam int         CHARS_WANTED = 460;
    localparam int         CYCLE_LIMIT  = 800000;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_NINE   = 8'h39;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] char_code
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [7:0] frame_byte, [10:8] status, rest zero
    logic        m_tlast;    // last

    int mismatches;
    int pending_results;
    int tx_gap_pct    = 0;
    int rx_stall_pct  = 0;
    int rx_stall_left = 0;
    int cycle_count   = 0;
    int chars_sent    = 0;
    int msg_index     = 0;
    int msg_counted;

    logic [7:0] msg_chars [$];

    decimal_id_to_hex_frame_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    dhfe_frame_check frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Idle length: mostly short, now and then long
    function automatic int gap_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Result side back-pressure
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_stall_left > 0)
            begin
                m_tready <= 1'b0;
                rx_stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < rx_stall_pct)
                    rx_stall_left = gap_length();
            end
        end
    end

    // One character request; returns at the falling edge after it is taken
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = ($urandom_range(0, 99) < tx_gap_pct) ? gap_length() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Sender holds off until every predicted result has drained
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] random_ws();
        case ($urandom_range(0, 3))
            0:       return CH_SP;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // Any byte that is neither digit, whitespace nor the zero byte
    function automatic logic [7:0] random_bad();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while ((c >= ASCII_ZERO && c <= ASCII_NINE) || c == CH_SP || c == CH_TAB ||
               c == CH_CR || c == CH_LF);
        return c;
    endfunction

    task automatic add_digits(input int n, input bit lead_nonzero);
        int d;
        for (int k = 0; k < n; k++)
        begin
            d = (k == 0 && lead_nonzero) ? $urandom_range(1, 9) : $urandom_range(0, 9);
            msg_chars.push_back(ASCII_ZERO + 8'(d));
        end
    endtask

    // Builds one message: mostly well formed numbers, some broken ones and noise
    task automatic compose_message();
        int    kind;
        bit    ws_end;
        string boundary;
        msg_chars.delete();
        kind   = $urandom_range(0, 99);
        ws_end = 1'b0;
        repeat ($urandom_range(0, 3)) msg_chars.push_back(random_ws());
        if (kind < 45)
            add_digits(($urandom_range(0, 4) == 0) ? 10 : $urandom_range(1, 9), 1'b0);
        else if (kind < 55)
        begin
            case ($urandom_range(0, 2))
                0:       boundary = "4294967295";
                1:       boundary = "4294967296";
                default: boundary = "000004294967295";
            endcase
            for (int i = 0; i < boundary.len(); i++)
                msg_chars.push_back(boundary[i]);
        end
        else if (kind < 65)
            add_digits($urandom_range(11, 15), 1'b1);
        else if (kind < 73)
            add_digits($urandom_range(16, 18), 1'b0);
        else if (kind < 85)
        begin
            add_digits($urandom_range(0, 4), 1'b0);
            msg_chars.push_back(random_bad());
        end
        else if (kind >= 93)
            repeat ($urandom_range(1, 6)) msg_chars.push_back(8'($urandom_range(0, 255)));

        // number kinds end at whitespace half of the time
        if (kind < 73 && $urandom_range(0, 1) == 1)
        begin
            msg_chars.push_back(random_ws());
            ws_end = 1'b1;
        end
        if (ws_end || (kind >= 73 && kind < 85))
            repeat ($urandom_range(0, 4)) msg_chars.push_back(8'($urandom_range(1, 255)));
        msg_chars.push_back(CH_NUL);
        msg_counted = msg_chars.size();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty message
        send_char(CH_NUL);
        // single digit closed by whitespace, then trailing text ignored
        send_text("\t9 x");
        send_char(CH_NUL);
        // top byte value as a non-digit after leading CR LF
        send_text("\r\n");
        send_char(8'hFF);
        send_char(CH_NUL);
        // digit followed by a character just above '9'
        send_text("0:");
        send_char(CH_NUL);
        // largest 32-bit value
        send_text("4294967295");
        send_char(CH_NUL);
        wait_drained();

        // Random messages with changing idle patterns
        while (chars_sent < CHARS_WANTED)
        begin
            if (msg_index % 12 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
                    1:       begin tx_gap_pct = 35; rx_stall_pct = 0;  end
                    2:       begin tx_gap_pct = 0;  rx_stall_pct = 35; end
                    default: begin tx_gap_pct = 35; rx_stall_pct = 35; end
                endcase
            end
            if (msg_index == 30)
                wait_drained();
            compose_message();
            foreach (msg_chars[i])
                send_char(msg_chars[i]);
            chars_sent += msg_counted;
            msg_index++;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
